>>> rtl/fpw_pkg.sv
// Shared widths, register indexes and types of the framebuffer pixel writer.
package fpw_pkg;

  localparam int RGB_W    = 24;
  localparam int POS_W    = 16;
  localparam int MASK_W   = 32;
  localparam int BPP_W    = 3;
  localparam int PITCH_W  = 18;
  localparam int OFF_W    = 35;
  localparam int PIX_W    = 32;
  localparam int LEVEL_W  = 8;
  localparam int SHIFT_W  = 5;
  localparam int WIDTH_W  = 6;
  localparam int PROD_W   = 40;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_STAGES = 6;
  localparam int MAX_BYTES  = 4;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_MASK     = 4'd0,
    REG_GREEN_MASK   = 4'd1,
    REG_BLUE_MASK    = 4'd2,
    REG_BYTES_PER_PX = 4'd3,
    REG_LINE_PITCH   = 4'd4,
    REG_LIMIT_X      = 4'd5,
    REG_LIMIT_Y      = 4'd6,
    REG_GFX_ENABLE   = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [MASK_W-1:0]  red_mask;
    logic [MASK_W-1:0]  green_mask;
    logic [MASK_W-1:0]  blue_mask;
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic [PITCH_W-1:0] line_pitch;
    logic [POS_W-1:0]   limit_x;
    logic [POS_W-1:0]   limit_y;
    logic               graphics_enabled;
  } cfg_t;

endpackage

>>> rtl/fpw_stream_if.sv
// Valid/ready stream interfaces for pixel requests and pixel write results.
interface fpw_in_if;
  logic                       valid;
  logic                       ready;
  logic [fpw_pkg::RGB_W-1:0]  rgb_color;
  logic [fpw_pkg::POS_W-1:0]  pos_x;
  logic [fpw_pkg::POS_W-1:0]  pos_y;

  modport source (output valid, output rgb_color, output pos_x, output pos_y, input ready);
  modport sink (input valid, input rgb_color, input pos_x, input pos_y, output ready);
endinterface

interface fpw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [fpw_pkg::OFF_W-1:0]  byte_offset;
  logic [fpw_pkg::PIX_W-1:0]  pixel_value;
  logic [fpw_pkg::BPP_W-1:0]  byte_count;

  modport source (output valid, output accepted, output byte_offset, output pixel_value,
                  output byte_count, input ready);
  modport sink (input valid, input accepted, input byte_offset, input pixel_value,
                input byte_count, output ready);
endinterface

>>> rtl/fpw_cfg_regs.sv
// Configuration register file of the framebuffer pixel writer.
module fpw_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output fpw_pkg::cfg_t                  cfg
);
  import fpw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_mask         <= 32'h00FF_0000;
      cfg.green_mask       <= 32'h0000_FF00;
      cfg.blue_mask        <= 32'h0000_00FF;
      cfg.bytes_per_pixel  <= BPP_W'(4);
      cfg.line_pitch       <= PITCH_W'(4096);
      cfg.limit_x          <= POS_W'(1023);
      cfg.limit_y          <= POS_W'(767);
      cfg.graphics_enabled <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED_MASK:     cfg.red_mask         <= cfg_wdata[MASK_W-1:0];
        REG_GREEN_MASK:   cfg.green_mask       <= cfg_wdata[MASK_W-1:0];
        REG_BLUE_MASK:    cfg.blue_mask        <= cfg_wdata[MASK_W-1:0];
        REG_BYTES_PER_PX: cfg.bytes_per_pixel  <= cfg_wdata[BPP_W-1:0];
        REG_LINE_PITCH:   cfg.line_pitch       <= cfg_wdata[PITCH_W-1:0];
        REG_LIMIT_X:      cfg.limit_x          <= cfg_wdata[POS_W-1:0];
        REG_LIMIT_Y:      cfg.limit_y          <= cfg_wdata[POS_W-1:0];
        REG_GFX_ENABLE:   cfg.graphics_enabled <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/fpw_chan_scale.sv
// One color channel: mask decode, scaling by the field maximum and division by 255.
module fpw_chan_scale (
  input  logic                         clk,
  input  fpw_pkg::stage_en_t           en,
  input  logic [fpw_pkg::MASK_W-1:0]   mask,
  input  logic [fpw_pkg::LEVEL_W-1:0]  level,
  output logic [fpw_pkg::PIX_W-1:0]    quot,
  output logic [fpw_pkg::SHIFT_W-1:0]  shift
);
  import fpw_pkg::*;

  logic [MASK_W-1:0]  low0, run0;
  logic [LEVEL_W-1:0] level0, level1;
  logic [WIDTH_W-1:0] width1;
  logic [SHIFT_W-1:0] shift1, shift2, shift3;
  logic [PROD_W-1:0]  prod2;
  logic [PIX_W-1:0]   acc3;
  logic [18:0]        rem3;

  logic [MASK_W-1:0]  low_c, run_c;
  logic [WIDTH_W-1:0] width_c;
  logic [SHIFT_W-1:0] shift_c;
  logic [PROD_W-1:0]  prod_c;
  logic [31:0] h1;
  logic [32:0] r1;
  logic [24:0] h2;
  logic [25:0] r2;
  logic [17:0] h3;
  logic [18:0] r3;
  logic [PIX_W-1:0] a3;
  logic [10:0] h4;
  logic [11:0] r4;
  logic [3:0]  h5;
  logic [8:0]  r5;
  logic        h6;
  logic [8:0]  r6;
  logic [PIX_W-1:0] q_c;

  // The lowest run of ones is cut out by adding its lowest bit to the mask.
  always_comb begin
    low_c = mask & (~mask + MASK_W'(1));
    run_c = mask & ~(mask + low_c);
  end

  always_comb begin
    width_c = '0;
    shift_c = '0;
    for (int i = 0; i < MASK_W; i++) begin
      width_c = width_c + WIDTH_W'(run0[i]);
    end
    for (int b = 0; b < SHIFT_W; b++) begin
      for (int i = 0; i < MASK_W; i++) begin
        if (((i >> b) & 1) == 1) begin
          shift_c[b] = shift_c[b] | low0[i];
        end
      end
    end
  end

  always_comb begin
    prod_c = (PROD_W'(level1) << width1) - PROD_W'(level1);
  end

  // Division by 255 uses 256*h + l = 255*h + (h + l), one byte fold a step.
  always_comb begin
    h1 = prod2[39:8];
    r1 = {1'b0, h1} + 33'(prod2[7:0]);
    h2 = r1[32:8];
    r2 = {1'b0, h2} + 26'(r1[7:0]);
    h3 = r2[25:8];
    r3 = {1'b0, h3} + 19'(r2[7:0]);
    a3 = h1 + PIX_W'(h2) + PIX_W'(h3);
  end

  always_comb begin
    h4 = rem3[18:8];
    r4 = {1'b0, h4} + 12'(rem3[7:0]);
    h5 = r4[11:8];
    r5 = 9'(h5) + 9'(r4[7:0]);
    h6 = r5[8];
    r6 = 9'(h6) + 9'(r5[7:0]);
    q_c = acc3 + PIX_W'(h4) + PIX_W'(h5) + PIX_W'(h6) + PIX_W'(r6 >= 9'd255);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      low0   <= low_c;
      run0   <= run_c;
      level0 <= level;
    end
    if (en[1]) begin
      width1 <= width_c;
      shift1 <= shift_c;
      level1 <= level0;
    end
    if (en[2]) begin
      prod2  <= prod_c;
      shift2 <= shift1;
    end
    if (en[3]) begin
      acc3   <= a3;
      rem3   <= r3;
      shift3 <= shift2;
    end
    if (en[4]) begin
      quot   <= q_c;
      shift  <= shift3;
    end
  end

endmodule

>>> rtl/fpw_addr_calc.sv
// Byte offset of a pixel from its column, row, pixel size and line pitch.
module fpw_addr_calc (
  input  logic                         clk,
  input  fpw_pkg::stage_en_t           en,
  input  logic [fpw_pkg::POS_W-1:0]    pos_x,
  input  logic [fpw_pkg::POS_W-1:0]    pos_y,
  input  logic [fpw_pkg::BPP_W-1:0]    bytes_per_pixel,
  input  logic [fpw_pkg::PITCH_W-1:0]  line_pitch,
  output logic [fpw_pkg::OFF_W-1:0]    byte_offset
);
  import fpw_pkg::*;

  localparam int XP_W = BPP_W + POS_W;
  localparam int YP_W = PITCH_W + POS_W;

  logic [POS_W-1:0]   x0, y0;
  logic [BPP_W-1:0]   bpp0;
  logic [PITCH_W-1:0] pitch0;
  logic [XP_W-1:0]    xp1;
  logic [YP_W-1:0]    yp1;
  logic [OFF_W-1:0]   off2, off3;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0     <= pos_x;
      y0     <= pos_y;
      bpp0   <= bytes_per_pixel;
      pitch0 <= line_pitch;
    end
    if (en[1]) begin
      xp1 <= XP_W'(bpp0) * XP_W'(x0);
      yp1 <= YP_W'(pitch0) * YP_W'(y0);
    end
    if (en[2]) begin
      off2 <= OFF_W'(xp1) + OFF_W'(yp1);
    end
    if (en[3]) begin
      off3 <= off2;
    end
    if (en[4]) begin
      byte_offset <= off3;
    end
  end

endmodule

>>> rtl/framebuffer_pixel_writer.sv
// Framebuffer pixel writer: converts an RGB888 color to the framebuffer pixel format
// set by three channel masks and computes the byte offset of the pixel. It takes one
// beat per clock while the pipeline has room or the output is taken; each result runs
// through the channel path (mask decode, field scaling, a two-stage divide by 255 and the
// final shift and merge in the output register). Each stage holds its beat only while
// the stage after it is full and stalled, so gaps in the stream are closed up under a
// stall. A beat with graphics off or a position past a limit gives a result of all zeros.
module framebuffer_pixel_writer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fpw_in_if.sink                         pix_in,
  fpw_out_if.source                      pix_out
);
  import fpw_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  cfg_t               cfg;
  stage_en_t          en;
  logic [LAST:0]      vld;
  logic [LAST-1:0]    ok_pipe;
  logic [BPP_W-1:0]   cnt_pipe [LAST];
  logic               ok_c;
  logic [BPP_W-1:0]   cnt_c;
  logic [PIX_W-1:0]   red_q, green_q, blue_q;
  logic [SHIFT_W-1:0] red_s, green_s, blue_s;
  logic [OFF_W-1:0]   offset;
  logic [PIX_W-1:0]   pixel_c;

  fpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpw_chan_scale u_red (
    .clk   (clk),
    .en    (en),
    .mask  (cfg.red_mask),
    .level (pix_in.rgb_color[23:16]),
    .quot  (red_q),
    .shift (red_s)
  );

  fpw_chan_scale u_green (
    .clk   (clk),
    .en    (en),
    .mask  (cfg.green_mask),
    .level (pix_in.rgb_color[15:8]),
    .quot  (green_q),
    .shift (green_s)
  );

  fpw_chan_scale u_blue (
    .clk   (clk),
    .en    (en),
    .mask  (cfg.blue_mask),
    .level (pix_in.rgb_color[7:0]),
    .quot  (blue_q),
    .shift (blue_s)
  );

  fpw_addr_calc u_addr (
    .clk             (clk),
    .en              (en),
    .pos_x           (pix_in.pos_x),
    .pos_y           (pix_in.pos_y),
    .bytes_per_pixel (cfg.bytes_per_pixel),
    .line_pitch      (cfg.line_pitch),
    .byte_offset     (offset)
  );

  always_comb begin
    en[LAST] = ~vld[LAST] | pix_out.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign pix_in.ready = en[0] & ~rst;

  always_comb begin
    ok_c  = cfg.graphics_enabled & (pix_in.pos_x <= cfg.limit_x)
          & (pix_in.pos_y <= cfg.limit_y);
    cnt_c = (cfg.bytes_per_pixel > BPP_W'(MAX_BYTES)) ? BPP_W'(MAX_BYTES)
                                                      : cfg.bytes_per_pixel;
    pixel_c = (red_q << red_s) | (green_q << green_s) | (blue_q << blue_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok_pipe[0]  <= ok_c;
      cnt_pipe[0] <= cnt_c;
    end
    for (int k = 1; k < LAST; k++) begin
      if (en[k]) begin
        ok_pipe[k]  <= ok_pipe[k-1];
        cnt_pipe[k] <= cnt_pipe[k-1];
      end
    end
    if (en[LAST]) begin
      pix_out.accepted    <= ok_pipe[LAST-1];
      pix_out.byte_offset <= ok_pipe[LAST-1] ? offset : '0;
      pix_out.pixel_value <= ok_pipe[LAST-1] ? pixel_c : '0;
      pix_out.byte_count  <= ok_pipe[LAST-1] ? cnt_pipe[LAST-1] : '0;
    end
  end

  assign pix_out.valid = vld[LAST];

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the framebuffer pixel writer with directed and random beats.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fpw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS  = 62;
  localparam int CALM_PHASES  = 2;
  localparam int POS_MAX      = 65535;
  localparam int PITCH_MAX    = 262143;
  localparam logic [63:0] LEVEL_MAX = 64'd255;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } pixel_req_t;

  typedef struct packed {
    logic             accepted;
    logic [OFF_W-1:0] offset;
    logic [PIX_W-1:0] pixel;
    logic [BPP_W-1:0] count;
  } pixel_wr_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fpw_in_if  pix_in_bus ();
  fpw_out_if pix_out_bus ();

  framebuffer_pixel_writer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pix_in    (pix_in_bus),
    .pix_out   (pix_out_bus)
  );

  always #10 clk = ~clk;

  cfg_t       shadow_cfg;
  pixel_req_t pending_pixels[$];
  pixel_wr_t  expected_writes[$];
  pixel_wr_t  want;
  pixel_wr_t  got;

  int  errors = 0;
  int  beats_in = 0;
  int  writes_checked = 0;
  int  writes_accepted = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;

  function automatic logic [63:0] scale_level(logic [MASK_W-1:0] mask, logic [LEVEL_W-1:0] level);
    int shift;
    int width;
    logic [63:0] ones;
    shift = 0;
    width = 0;
    if (mask == '0) return 64'd0;
    while (shift < MASK_W && !mask[shift]) shift++;
    while (shift + width < MASK_W && mask[shift + width]) width++;
    ones = (64'd1 << width) - 64'd1;
    return ((ones * 64'(level)) / LEVEL_MAX) << shift;
  endfunction

  function automatic pixel_wr_t translate_pixel(pixel_req_t req, cfg_t c);
    pixel_wr_t w;
    logic [63:0] pix;
    logic [63:0] off;
    w = '0;
    if (c.graphics_enabled && req.x <= c.limit_x && req.y <= c.limit_y) begin
      pix = scale_level(c.red_mask, req.rgb[23:16])
          | scale_level(c.green_mask, req.rgb[15:8])
          | scale_level(c.blue_mask, req.rgb[7:0]);
      off = 64'(c.bytes_per_pixel) * 64'(req.x) + 64'(c.line_pitch) * 64'(req.y);
      w.accepted = 1'b1;
      w.offset   = off[OFF_W-1:0];
      w.pixel    = pix[PIX_W-1:0];
      w.count    = (c.bytes_per_pixel > MAX_BYTES) ? BPP_W'(MAX_BYTES) : c.bytes_per_pixel;
    end
    return w;
  endfunction

  function automatic logic [MASK_W-1:0] random_field();
    int w;
    int s;
    w = $urandom_range(1, MASK_W);
    s = $urandom_range(0, MASK_W - w);
    return MASK_W'(((64'd1 << w) - 64'd1) << s);
  endfunction

  function automatic logic [MASK_W-1:0] random_odd_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return POS_MAX;
      2, 3: return $urandom_range(0, POS_MAX);
      default: return $urandom_range(1, 2047);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(int limit);
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, POS_MAX);
      1: begin
        v = limit + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (v > POS_MAX) v = POS_MAX;
      end
      2: v = $urandom_range(0, limit);
      default: v = $urandom_range(0, 1) ? POS_MAX : 0;
    endcase
    return POS_W'(v);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_RED_MASK:     shadow_cfg.red_mask         = data[MASK_W-1:0];
      REG_GREEN_MASK:   shadow_cfg.green_mask       = data[MASK_W-1:0];
      REG_BLUE_MASK:    shadow_cfg.blue_mask        = data[MASK_W-1:0];
      REG_BYTES_PER_PX: shadow_cfg.bytes_per_pixel  = data[BPP_W-1:0];
      REG_LINE_PITCH:   shadow_cfg.line_pitch       = data[PITCH_W-1:0];
      REG_LIMIT_X:      shadow_cfg.limit_x          = data[POS_W-1:0];
      REG_LIMIT_Y:      shadow_cfg.limit_y          = data[POS_W-1:0];
      REG_GFX_ENABLE:   shadow_cfg.graphics_enabled = data[0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                       int bpp, int pitch, int lx, int ly, int en);
    write_reg(REG_RED_MASK, r);
    write_reg(REG_GREEN_MASK, g);
    write_reg(REG_BLUE_MASK, b);
    write_reg(REG_BYTES_PER_PX, 32'(bpp));
    write_reg(REG_LINE_PITCH, 32'(pitch));
    write_reg(REG_LIMIT_X, 32'(lx));
    write_reg(REG_LIMIT_Y, 32'(ly));
    write_reg(REG_GFX_ENABLE, 32'(en));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(int rgb, int x, int y);
    pixel_req_t req;
    req.rgb = RGB_W'(rgb);
    req.x   = POS_W'(x);
    req.y   = POS_W'(y);
    pending_pixels.push_back(req);
  endtask

  task automatic wait_drain();
    while (pending_pixels.size() != 0 || expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: offers the oldest pending beat and holds it until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      pix_in_bus.valid <= 1'b0;
    end else begin
      if (pix_in_bus.valid && pix_in_bus.ready) begin
        expected_writes.push_back(translate_pixel(pending_pixels.pop_front(), shadow_cfg));
        beats_in++;
      end
      if (pix_in_bus.valid && !pix_in_bus.ready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        pix_in_bus.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 12) - 1;
        pix_in_bus.valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        pix_in_bus.valid     <= 1'b1;
        pix_in_bus.rgb_color <= pending_pixels[0].rgb;
        pix_in_bus.pos_x     <= pending_pixels[0].x;
        pix_in_bus.pos_y     <= pending_pixels[0].y;
      end else begin
        pix_in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pix_out_bus.ready <= 1'b0;
    end else begin
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        got.accepted = pix_out_bus.accepted;
        got.offset   = pix_out_bus.byte_offset;
        got.pixel    = pix_out_bus.pixel_value;
        got.count    = pix_out_bus.byte_count;
        if (expected_writes.size() == 0) begin
          errors++;
          $display("%0t: result beat with no prediction waiting, got %p", $time, got);
        end else begin
          want = expected_writes.pop_front();
          writes_checked++;
          if (want.accepted) writes_accepted++;
          if (got.accepted !== want.accepted) begin
            errors++;
            $display("%0t: accepted mismatch, expected %0d, got %0d",
                     $time, want.accepted, got.accepted);
          end
          if (got.offset !== want.offset) begin
            errors++;
            $display("%0t: byte_offset mismatch, expected %h, got %h",
                     $time, want.offset, got.offset);
          end
          if (got.pixel !== want.pixel) begin
            errors++;
            $display("%0t: pixel_value mismatch, expected %h, got %h",
                     $time, want.pixel, got.pixel);
          end
          if (got.count !== want.count) begin
            errors++;
            $display("%0t: byte_count mismatch, expected %0d, got %0d",
                     $time, want.count, got.count);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pix_out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 12) - 1;
        pix_out_bus.ready <= 1'b0;
      end else begin
        pix_out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_writes.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    int bpp;
    int pitch;
    int lx;
    int ly;
    int en;

    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    pix_in_bus.valid     = 1'b0;
    pix_in_bus.rgb_color = '0;
    pix_in_bus.pos_x     = '0;
    pix_in_bus.pos_y     = '0;
    pix_out_bus.ready    = 1'b0;
    shadow_cfg = '{red_mask: 32'h00FF0000, green_mask: 32'h0000FF00,
                   blue_mask: 32'h000000FF, bytes_per_pixel: 3'd4,
                   line_pitch: 18'd4096, limit_x: 16'd1023, limit_y: 16'd767,
                   graphics_enabled: 1'b0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings leave graphics disabled, so every write is rejected.
    send(24'hFFFFFF, 0, 0);
    send(24'h123456, 1023, 767);
    wait_drain();

    setup(32'h00FF0000, 32'h0000FF00, 32'h000000FF, 4, 4096, 1023, 767, 1);
    send(24'h000000, 0, 0);
    send(24'hFFFFFF, 1023, 767);
    send(24'hFFFFFF, 1024, 0);
    send(24'h123456, 0, 768);
    send(24'h808080, 5, 7);
    wait_drain();

    write_reg(CFG_UNUSED_IDX, 32'hFFFFFFFF);
    setup(32'h0000F800, 32'h000007E0, 32'h0000001F, 2, 1280, 639, 479, 1);
    send(24'hFFFFFF, 639, 479);
    send(24'h7F3F01, 17, 3);
    wait_drain();

    // Zero, split and full masks with the widest geometry.
    setup(32'h00000000, 32'h0000F0F0, 32'hFFFFFFFF, 0, PITCH_MAX, POS_MAX, POS_MAX, 1);
    send(24'hFFFFFF, POS_MAX, POS_MAX);
    send(24'h000000, POS_MAX, 0);
    send(24'hA5C3E7, 12345, 54321);
    wait_drain();

    // Overlapping masks, oversized pixel size, zero pitch and zero limits.
    setup(32'h0000FFFF, 32'h0000FF00, 32'h00000FF0, 7, 0, 0, 0, 1);
    send(24'hFF00FF, 0, 0);
    send(24'h0F0F0F, 1, 0);
    send(24'hF0F0F0, 0, 1);
    send(24'h5A5A5A, POS_MAX, POS_MAX);
    wait_drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 6))
        0: begin r = 32'h00FF0000; g = 32'h0000FF00; b = 32'h000000FF; end
        1: begin r = 32'h000000FF; g = 32'h0000FF00; b = 32'h00FF0000; end
        2: begin r = 32'h0000F800; g = 32'h000007E0; b = 32'h0000001F; end
        3: begin r = 32'h00007C00; g = 32'h000003E0; b = 32'h0000001F; end
        4, 5: begin r = random_field(); g = random_field(); b = random_field(); end
        default: begin r = random_odd_mask(); g = random_odd_mask(); b = random_odd_mask(); end
      endcase
      case ($urandom_range(0, 7))
        6: bpp = 0;
        7: bpp = $urandom_range(5, 7);
        default: bpp = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 5))
        0: pitch = 0;
        1: pitch = PITCH_MAX;
        default: pitch = $urandom_range(0, PITCH_MAX);
      endcase
      lx = pick_limit();
      ly = pick_limit();
      en = ($urandom_range(0, 5) != 0);
      setup(r, g, b, bpp, pitch, lx, ly, en);
      calm = (p >= RANDOM_PHASES - CALM_PHASES);
      if (p == 3) hold_req++;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 5 && i == PHASE_BEATS / 2) wait_drain();
        send($urandom, pick_pos(lx), pick_pos(ly));
      end
      wait_drain();
    end

    $display("Sent %0d pixel beats over %0d settings, %0d results checked, %0d accepted",
             beats_in, RANDOM_PHASES + 5, writes_checked, writes_accepted);
    $display("Mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
